/* rtl/core/tcw_pkg.sv */
// Shared constants, types and command codes for the text console writer.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  // Widths
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CLR_W  = 4;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Character and attribute codes
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
  localparam logic [CLR_W-1:0]  RESET_FG     = 4'hF;
  localparam logic [CLR_W-1:0]  RESET_BG     = 4'h0;

  // Configuration register indexes
  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  // Write data select
  localparam logic [1:0] WS_RESET  = 2'd0;  // reset blank cell at counter
  localparam logic [1:0] WS_BLANK  = 2'd1;  // blank in current attribute at counter
  localparam logic [1:0] WS_CURSOR = 2'd2;  // character at cursor

  // Counter preset select
  localparam logic [1:0] CS_ZERO   = 2'd0;
  localparam logic [1:0] CS_SECOND = 2'd1;  // first cell of the second row
  localparam logic [1:0] CS_BOTTOM = 2'd2;  // first cell of the bottom row

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CELL_W-1:0] cell_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_req;
    logic       cnt_set;
    logic [1:0] cnt_sel;
    logic       cnt_inc;
    logic       mem_wr;
    logic [1:0] wr_sel;
    logic       rd_idx;
    logic       scroll_rd;
    logic       col_zero;
    logic       row_inc;
    logic       col_inc;
    logic       out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             is_newline;
    logic             col_full;
    logic             row_last;
    logic             cnt_last;
    logic             out_free;
  } sts_t;

endpackage

/* rtl/core/tcw_if.sv */
// Request and response channel interfaces of the text console writer.
interface tcw_req_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, req_type, char_code, cell_index, input ready);
  modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_pos;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;

  modport source (output valid, cursor_pos, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_pos, cell_char, cell_attr, output ready);
endinterface

/* rtl/core/tcw_datapath.sv */
// Datapath: cell store, cursor, color registers, sweep counter and response register.
module tcw_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  tcw_pkg::cmd_t             cmd,
  output tcw_pkg::sts_t             sts,
  input  logic [tcw_pkg::REQ_W-1:0]  req_type,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::IDX_W-1:0]  cell_index,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [tcw_pkg::CLR_W-1:0]  cfg_wdata,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic [tcw_pkg::POS_W-1:0]  rsp_cursor_pos,
  output logic [tcw_pkg::CHAR_W-1:0] rsp_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0] rsp_cell_attr
);
  import tcw_pkg::*;

  localparam logic [POS_W-1:0] COL_CNT = POS_W'(COLUMNS);

  cell_t             mem [CELL_COUNT];
  cell_t             rdata;
  logic [CLR_W-1:0]  fg_color;
  logic [CLR_W-1:0]  bg_color;
  logic [REQ_W-1:0]  req_q;
  logic [CHAR_W-1:0] char_q;
  logic [IDX_W-1:0]  idx_q;
  row_t              cursor_row;
  col_t              cursor_col;
  addr_t             cnt;
  logic              sc_pend;
  addr_t             sc_addr;
  logic [POS_W-1:0]  cur_lin;
  logic [ATTR_W-1:0] attr;
  logic              idx_ok;
  logic              wr_en;
  addr_t             wr_addr;
  cell_t             wr_data;

  assign attr    = {bg_color, fg_color};
  assign cur_lin = POS_W'(cursor_row) * COL_CNT + POS_W'(cursor_col);
  assign idx_ok  = idx_q < IDX_W'(CELL_COUNT);

  // Status for the controller
  assign sts.req_type   = req_q;
  assign sts.is_newline = char_q == NEWLINE_CODE;
  assign sts.col_full   = cursor_col >= COL_W'(COLUMNS);
  assign sts.row_last   = cursor_row == ROW_W'(ROWS - 1);
  assign sts.cnt_last   = cnt == ADDR_W'(CELL_COUNT - 1);
  assign sts.out_free   = !rsp_valid || rsp_ready;

  // Color registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= RESET_FG;
      bg_color <= RESET_BG;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_FG) begin
        fg_color <= cfg_wdata;
      end else begin
        bg_color <= cfg_wdata;
      end
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q  <= req_type;
      char_q <= char_code;
      idx_q  <= cell_index;
    end
  end

  // Cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= '0;
      cursor_col <= '0;
    end else begin
      if (cmd.row_inc) begin
        cursor_row <= cursor_row + ROW_W'(1);
      end
      if (cmd.col_zero) begin
        cursor_col <= '0;
      end else if (cmd.col_inc) begin
        cursor_col <= cursor_col + COL_W'(1);
      end
    end
  end

  // Sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_set) begin
      case (cmd.cnt_sel)
        CS_ZERO:   cnt <= '0;
        CS_SECOND: cnt <= ADDR_W'(COLUMNS);
        CS_BOTTOM: cnt <= ADDR_W'(CELL_COUNT - COLUMNS);
        default:   cnt <= '0;
      endcase
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + ADDR_W'(1);
    end
  end

  // Scroll copy: a read at cnt is written one row up in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sc_pend <= 1'b0;
    end else begin
      sc_pend <= cmd.scroll_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scroll_rd) begin
      sc_addr <= cnt - ADDR_W'(COLUMNS);
    end
  end

  // Select the single write of this cycle
  always_comb begin
    wr_en   = sc_pend || cmd.mem_wr;
    wr_addr = cnt;
    wr_data = {RESET_ATTR, SPACE_CODE};
    if (sc_pend) begin
      wr_addr = sc_addr;
      wr_data = rdata;
    end else begin
      case (cmd.wr_sel)
        WS_RESET: begin
          wr_addr = cnt;
          wr_data = {RESET_ATTR, SPACE_CODE};
        end
        WS_BLANK: begin
          wr_addr = cnt;
          wr_data = {attr, SPACE_CODE};
        end
        WS_CURSOR: begin
          wr_addr = ADDR_W'(cur_lin);
          wr_data = {attr, char_q};
        end
        default: begin
          wr_addr = cnt;
          wr_data = {RESET_ATTR, SPACE_CODE};
        end
      endcase
    end
  end

  // Cell store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scroll_rd) begin
      rdata <= mem[cnt];
    end else if (cmd.rd_idx && idx_ok) begin
      rdata <= mem[ADDR_W'(idx_q)];
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_cursor_pos <= cur_lin;
      if (req_q == REQ_READ && idx_ok) begin
        rsp_cell_char <= rdata[CHAR_W-1:0];
        rsp_cell_attr <= rdata[CELL_W-1:CHAR_W];
      end else begin
        rsp_cell_char <= '0;
        rsp_cell_attr <= '0;
      end
    end
  end

endmodule

/* rtl/core/tcw_ctrl.sv */
// Controller state machine: sequences request decode, sweeps, writes and the response.
module tcw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t cmd
);
  import tcw_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_FILL   = 4'd3;
  localparam logic [3:0] S_SCROLL = 4'd4;
  localparam logic [3:0] S_DRAIN  = 4'd5;
  localparam logic [3:0] S_BOTTOM = 4'd6;
  localparam logic [3:0] S_WRITE  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      // Clear the store to reset cells after reset
      S_INIT: begin
        cmd.mem_wr  = 1'b1;
        cmd.wr_sel  = WS_RESET;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      // Take one item
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req_type)
          REQ_PUT: begin
            if (sts.is_newline || sts.col_full) begin
              cmd.col_zero = 1'b1;
              if (sts.row_last) begin
                cmd.cnt_set = 1'b1;
                cmd.cnt_sel = CS_SECOND;
                state_next  = S_SCROLL;
              end else begin
                cmd.row_inc = 1'b1;
                state_next  = sts.is_newline ? S_DONE : S_WRITE;
              end
            end else begin
              state_next = S_WRITE;
            end
          end
          REQ_CLEAR: begin
            cmd.cnt_set = 1'b1;
            cmd.cnt_sel = CS_ZERO;
            state_next  = S_FILL;
          end
          REQ_READ: begin
            cmd.rd_idx = 1'b1;
            state_next = S_DONE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      // Blank every cell in the current attribute
      S_FILL: begin
        cmd.mem_wr  = 1'b1;
        cmd.wr_sel  = WS_BLANK;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_DONE;
        end
      end
      // Copy rows up one cell per cycle
      S_SCROLL: begin
        cmd.scroll_rd = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_DRAIN;
        end
      end
      // Let the last copy write land, then point at the bottom row
      S_DRAIN: begin
        cmd.cnt_set = 1'b1;
        cmd.cnt_sel = CS_BOTTOM;
        state_next  = S_BOTTOM;
      end
      S_BOTTOM: begin
        cmd.mem_wr  = 1'b1;
        cmd.wr_sel  = WS_BLANK;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          state_next = sts.is_newline ? S_DONE : S_WRITE;
        end
      end
      // Store the character and advance the column
      S_WRITE: begin
        cmd.mem_wr  = 1'b1;
        cmd.wr_sel  = WS_CURSOR;
        cmd.col_inc = 1'b1;
        state_next  = S_DONE;
      end
      // Hand the result to the response register
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/text_console_writer.sv */
// Text console writer: 80x25 cell store with cursor, character, clear and read requests.
// After reset a clearing pass writes all 2000 cells; no item is taken meanwhile.
// Character write: decode, write, done; read or newline with no scroll: decode, done.
// Scroll: 1920 copies, a drain state, 80 blanks (one write port); clear blanks all cells.
// One item at a time, taken only in idle; a result may wait in the output register.
// Reset is synchronous, active high: cursor to 0, colors to fg 15 / bg 0.
module text_console_writer (
  input  logic                      clk,
  input  logic                      rst,
  tcw_req_if.sink                   req,
  tcw_rsp_if.source                 rsp,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [tcw_pkg::CLR_W-1:0]  cfg_wdata
);
  import tcw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_type       (req.req_type),
    .char_code      (req.char_code),
    .cell_index     (req.cell_index),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_cursor_pos (rsp.cursor_pos),
    .rsp_cell_char  (rsp.cell_char),
    .rsp_cell_attr  (rsp.cell_attr)
  );

endmodule
